>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file sdtq_checker
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define SDTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SDTQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sdtq_pkg.sv
// types, codes and constants of the sorted deadline timer queue
// no dependencies; used by every module of the block
`default_nettype none

package sdtq_pkg;

  // fixed field widths
  localparam int DL_W  = 32;
  localparam int TAG_W = 8;

  // default sizes handed down from the top level
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 8;

  // most results one tick may produce
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS);

  // command kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] RES_ADD     = 2'd0;
  localparam logic [1:0] RES_CANCEL  = 2'd1;
  localparam logic [1:0] RES_EXPIRED = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DL_W-1:0]  now_seconds;
    logic [DL_W-1:0]  delay_seconds;
    logic [DL_W-1:0]  cancel_deadline;
    logic [TAG_W-1:0] event_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [DL_W-1:0]  deadline;
    logic [TAG_W-1:0] tag;
    logic [1:0]       status;
    logic             last;
  } out_item_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE_GE,
    OP_SHIFT_ALL
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [DL_W-1:0] key;
  } cell_cmd_t;

  // summary the chain reports to the controller
  typedef struct packed {
    logic            hit;
    logic            full;
    logic            head_valid;
    logic [DL_W-1:0] head_deadline;
    logic            next_valid;
    logic [DL_W-1:0] next_deadline;
  } chain_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RAISE,
    S_CANCEL,
    S_TICK
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sdtq_cell.sv
// one slot of the sorted chain: deadline, tag and valid bit
// depends on sdtq_pkg; instantiated by sdtq_chain
`default_nettype none

module sdtq_cell
  import sdtq_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_cmd_t           cmd,
  input  logic [TAG_BITS-1:0] ins_tag,
  input  logic                left_lt,
  input  logic                left_valid,
  input  logic [DL_W-1:0]     left_deadline,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic                right_valid,
  input  logic [DL_W-1:0]     right_deadline,
  input  logic [TAG_BITS-1:0] right_tag,
  output logic                valid,
  output logic [DL_W-1:0]     deadline,
  output logic [TAG_BITS-1:0] tag,
  output logic                lt,
  output logic                eq
);

  logic                valid_r, valid_nxt;
  logic [DL_W-1:0]     deadline_r, deadline_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  // compares against the broadcast key
  assign lt = valid_r && (deadline_r < cmd.key);
  assign eq = valid_r && (deadline_r == cmd.key);

  // keep, take the new entry, or take a neighbor's entry
  always_comb begin
    valid_nxt    = valid_r;
    deadline_nxt = deadline_r;
    tag_nxt      = tag_r;
    case (cmd.op)
      OP_INSERT: begin
        if (!lt) begin
          if (left_lt) begin
            valid_nxt    = 1'b1;
            deadline_nxt = cmd.key;
            tag_nxt      = ins_tag;
          end else begin
            valid_nxt    = left_valid;
            deadline_nxt = left_deadline;
            tag_nxt      = left_tag;
          end
        end
      end
      OP_REMOVE_GE: begin
        if (!lt) begin
          valid_nxt    = right_valid;
          deadline_nxt = right_deadline;
          tag_nxt      = right_tag;
        end
      end
      OP_SHIFT_ALL: begin
        valid_nxt    = right_valid;
        deadline_nxt = right_deadline;
        tag_nxt      = right_tag;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  // valid bit is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    tag_r      <= tag_nxt;
  end

  assign valid    = valid_r;
  assign deadline = deadline_r;
  assign tag      = tag_r;

endmodule

`default_nettype wire

>>> hw/rtl/sdtq_chain.sv
// row of sdtq_cell slots kept sorted by ascending deadline
// depends on sdtq_pkg and sdtq_cell; instantiated by the top level
`default_nettype none

module sdtq_chain
  import sdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_cmd_t           cmd,
  input  logic [TAG_BITS-1:0] ins_tag,
  output chain_stat_t         stat,
  output logic [TAG_BITS-1:0] head_tag
);

  logic                valid_w    [QUEUE_DEPTH];
  logic [DL_W-1:0]     deadline_w [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_w      [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] lt_w;
  logic [QUEUE_DEPTH-1:0] eq_w;

  // neighbor links: the head sees an always-smaller left side,
  // the tail sees an empty right side
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                l_lt, l_valid, r_valid;
    logic [DL_W-1:0]     l_deadline, r_deadline;
    logic [TAG_BITS-1:0] l_tag, r_tag;

    if (i == 0) begin : g_head
      assign l_lt       = 1'b1;
      assign l_valid    = 1'b0;
      assign l_deadline = '0;
      assign l_tag      = '0;
    end else begin : g_mid
      assign l_lt       = lt_w[i-1];
      assign l_valid    = valid_w[i-1];
      assign l_deadline = deadline_w[i-1];
      assign l_tag      = tag_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid    = 1'b0;
      assign r_deadline = '0;
      assign r_tag      = '0;
    end else begin : g_body
      assign r_valid    = valid_w[i+1];
      assign r_deadline = deadline_w[i+1];
      assign r_tag      = tag_w[i+1];
    end

    sdtq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cmd),
      .ins_tag       (ins_tag),
      .left_lt       (l_lt),
      .left_valid    (l_valid),
      .left_deadline (l_deadline),
      .left_tag      (l_tag),
      .right_valid   (r_valid),
      .right_deadline(r_deadline),
      .right_tag     (r_tag),
      .valid         (valid_w[i]),
      .deadline      (deadline_w[i]),
      .tag           (tag_w[i]),
      .lt            (lt_w[i]),
      .eq            (eq_w[i])
    );
  end

  // summary for the controller
  always_comb begin
    stat.hit           = |eq_w;
    stat.full          = valid_w[QUEUE_DEPTH-1];
    stat.head_valid    = valid_w[0];
    stat.head_deadline = deadline_w[0];
    stat.next_valid    = valid_w[1];
    stat.next_deadline = deadline_w[1];
  end

  assign head_tag = tag_w[0];

endmodule

`default_nettype wire

>>> hw/rtl/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue: command sequencer
// depends on sdtq_pkg and sdtq_chain
//
// Usage. A command is transferred when start is high and busy is low;
// in_item carries kind, times, cancel key and tag. Results leave on
// out_item, each for one cycle with out_strobe high; the receiver
// cannot stall, so every strobed cycle is a transfer.
// Add: the base deadline is registered first, then the key steps past each
// held value in turn (at most QUEUE_DEPTH - 1), then the insert is made; the
// result shows the cycle after the insert.
// An add to a full queue answers in the cycle after the command.
// Cancel: the key is registered, then compared in every cell at once; the
// result of that compare is registered before it shows.
// Tick: the head cell is checked once a cycle and popped while due;
// one expired result per cycle, up to MAX_RESULTS, last flagged.
// busy stays high until the final result is in the output register,
// and a new command may be transferred in the cycle that result shows.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module sorted_deadline_timer_queue
  import sdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  state_t              state_r, state_nxt;
  logic [DL_W-1:0]     key_r, key_nxt;
  logic [DL_W-1:0]     now_r, now_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [NRES_W-1:0]   nres_r, nres_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_item_t           out_item_r, out_item_nxt;

  cell_cmd_t           cmd;
  chain_stat_t         stat;
  logic [TAG_BITS-1:0] head_tag;
  logic                accept;
  logic                head_due;
  logic                last_pop;

  sdtq_chain #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .ins_tag (tag_r),
    .stat    (stat),
    .head_tag(head_tag)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // expiry test on the head and the entry behind it
  assign head_due = stat.head_valid && (stat.head_deadline <= now_r);
  assign last_pop = (nres_r == NRES_W'(MAX_RESULTS - 1)) || !stat.next_valid ||
                    (stat.next_deadline > now_r);

  // sequencer: next state, chain command and result register
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    tag_nxt        = tag_r;
    nres_nxt       = nres_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    cmd.op         = OP_HOLD;
    cmd.key        = key_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.kind)
            KIND_ADD: begin
              tag_nxt = TAG_BITS'(in_item.event_tag);
              if (stat.full) begin
                out_strobe_nxt           = 1'b1;
                out_item_nxt.result_kind = RES_ADD;
                out_item_nxt.deadline    = '0;
                out_item_nxt.tag         = TAG_W'(TAG_BITS'(in_item.event_tag));
                out_item_nxt.status      = STAT_FULL;
                out_item_nxt.last        = 1'b1;
              end else begin
                key_nxt   = (in_item.delay_seconds == '0) ? '0 :
                            DL_W'(in_item.now_seconds + in_item.delay_seconds);
                state_nxt = S_RAISE;
              end
            end
            KIND_CANCEL: begin
              key_nxt   = in_item.cancel_deadline;
              tag_nxt   = TAG_BITS'(in_item.event_tag);
              state_nxt = S_CANCEL;
            end
            KIND_TICK: begin
              now_nxt   = in_item.now_seconds;
              nres_nxt  = '0;
              state_nxt = S_TICK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RAISE: begin
        // step past held deadlines, then insert in order
        if (stat.hit) begin
          key_nxt = DL_W'(key_r + 1'b1);
        end else begin
          cmd.op                   = OP_INSERT;
          out_strobe_nxt           = 1'b1;
          out_item_nxt.result_kind = RES_ADD;
          out_item_nxt.deadline    = key_r;
          out_item_nxt.tag         = TAG_W'(tag_r);
          out_item_nxt.status      = STAT_OK;
          out_item_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_CANCEL: begin
        // deadline zero is never cancelled
        out_strobe_nxt           = 1'b1;
        out_item_nxt.result_kind = RES_CANCEL;
        out_item_nxt.deadline    = key_r;
        out_item_nxt.tag         = TAG_W'(tag_r);
        out_item_nxt.last        = 1'b1;
        if ((key_r != '0) && stat.hit) begin
          cmd.op              = OP_REMOVE_GE;
          out_item_nxt.status = STAT_OK;
        end else begin
          out_item_nxt.status = STAT_NOT_FOUND;
        end
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        // pop one due entry per cycle
        if (head_due) begin
          cmd.op                   = OP_SHIFT_ALL;
          out_strobe_nxt           = 1'b1;
          out_item_nxt.result_kind = RES_EXPIRED;
          out_item_nxt.deadline    = stat.head_deadline;
          out_item_nxt.tag         = TAG_W'(head_tag);
          out_item_nxt.status      = STAT_OK;
          out_item_nxt.last        = last_pop;
          nres_nxt                 = NRES_W'(nres_r + 1'b1);
          if (last_pop) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    tag_r      <= tag_nxt;
    nres_r     <= nres_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

>>> hw/rtl/sdtq_checker.sv
// port-level checks of the sorted deadline timer queue, bound to the top
// depends on sdtq_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module sdtq_checker
  import sdtq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_strobe,
  input out_item_t out_item
);

  // reset leaves the block idle with no result showing
  `SDTQ_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !busy && !out_strobe, "not idle after reset")

  // a full answer carries deadline zero and ends its command
  `SDTQ_ASSERT(a_full_form, clk, rst_n, out_strobe && out_item.status == STAT_FULL |-> out_item.deadline == '0 && out_item.last && out_item.result_kind == RES_ADD, "bad full answer")

  // a full answer follows an add transfer directly
  `SDTQ_ASSERT(a_full_timing, clk, rst_n, out_strobe && out_item.status == STAT_FULL |-> $past(start && !busy && in_item.kind == KIND_ADD), "full answer without add")

  // add and cancel answers are single results
  `SDTQ_ASSERT(a_single_last, clk, rst_n, out_strobe && out_item.result_kind != RES_EXPIRED |-> out_item.last, "answer not last")

  // no command is taken while a tick still has results pending
  `SDTQ_ASSERT(a_tick_busy, clk, rst_n, out_strobe && out_item.result_kind == RES_EXPIRED && !out_item.last |-> busy, "idle mid tick")

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (.*);

`default_nettype wire

>>> sim/tb_sorted_deadline_timer_queue.sv
// self-checking testbench for the sorted deadline timer queue; depends on sdtq_pkg
// and sorted_deadline_timer_queue; a shadow timer list predicts each answer not
// typed in, checked field by field through a directed table and random commands
`default_nettype none

module tb_sorted_deadline_timer_queue;
  import sdtq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int RANDOM_CMDS = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  // command code the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    int unsigned reps;
    in_item_t    cmd;
    bit          fixed;
    out_item_t   ans;
  } dir_row_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  // shadow copy of the pending timers, sorted by deadline
  logic [DL_W-1:0]  shadow_dl[$];
  logic [TAG_W-1:0] shadow_tag[$];

  // answers owed by the block, oldest first
  out_item_t answers_due[$];
  out_item_t cmd_answers[$];

  // answer typed into the directed table for the command on the port
  bit        cmd_fixed = 1'b0;
  out_item_t cmd_fixed_ans = '0;

  bit          idle_on = 1'b1;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;

  dir_row_t dir_table[18];

  sorted_deadline_timer_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic in_item_t make_cmd(logic [1:0] kind, logic [DL_W-1:0] now_s,
                                        logic [DL_W-1:0] delay_s, logic [DL_W-1:0] cdl,
                                        logic [TAG_W-1:0] tag);
    in_item_t c;
    c.kind            = kind;
    c.now_seconds     = now_s;
    c.delay_seconds   = delay_s;
    c.cancel_deadline = cdl;
    c.event_tag       = tag;
    return c;
  endfunction

  function automatic out_item_t make_ans(logic [1:0] rk, logic [DL_W-1:0] dl,
                                         logic [TAG_W-1:0] tag, logic [1:0] st, logic lst);
    out_item_t a;
    a.result_kind = rk;
    a.deadline    = dl;
    a.tag         = tag;
    a.status      = st;
    a.last        = lst;
    return a;
  endfunction

  function automatic in_item_t random_cmd();
    return make_cmd(2'($urandom), $urandom, $urandom, $urandom, TAG_W'($urandom));
  endfunction

  function automatic bit deadline_held(logic [DL_W-1:0] d);
    foreach (shadow_dl[i])
      if (shadow_dl[i] == d) return 1'b1;
    return 1'b0;
  endfunction

  // advance the shadow list by one command and collect the answers it owes
  task automatic predict_timer_cmd(input in_item_t c);
    logic [DL_W-1:0] d;
    int              pos;
    int              i;
    int              n;
    cmd_answers.delete();
    case (c.kind)
      KIND_ADD: begin
        if (shadow_dl.size() >= DEPTH) begin
          cmd_answers.push_back(make_ans(RES_ADD, '0, c.event_tag, STAT_FULL, 1'b1));
        end else begin
          d = (c.delay_seconds == 0) ? '0 : c.now_seconds + c.delay_seconds;
          // step past deadlines already taken, wrapping at the top
          for (i = 0; i <= DEPTH && deadline_held(d); i++) d = d + 1'b1;
          pos = 0;
          while (pos < shadow_dl.size() && shadow_dl[pos] < d) pos++;
          shadow_dl.insert(pos, d);
          shadow_tag.insert(pos, c.event_tag);
          cmd_answers.push_back(make_ans(RES_ADD, d, c.event_tag, STAT_OK, 1'b1));
        end
      end
      KIND_CANCEL: begin
        pos = -1;
        // deadline zero never matches
        if (c.cancel_deadline != 0)
          foreach (shadow_dl[j])
            if (pos < 0 && shadow_dl[j] == c.cancel_deadline) pos = j;
        if (pos >= 0) begin
          shadow_dl.delete(pos);
          shadow_tag.delete(pos);
          cmd_answers.push_back(make_ans(RES_CANCEL, c.cancel_deadline, c.event_tag,
                                         STAT_OK, 1'b1));
        end else begin
          cmd_answers.push_back(make_ans(RES_CANCEL, c.cancel_deadline, c.event_tag,
                                         STAT_NOT_FOUND, 1'b1));
        end
      end
      KIND_TICK: begin
        n = 0;
        while (n < MAX_RESULTS && shadow_dl.size() > 0 && shadow_dl[0] <= c.now_seconds) begin
          cmd_answers.push_back(make_ans(RES_EXPIRED, shadow_dl[0], shadow_tag[0],
                                         STAT_OK, 1'b0));
          void'(shadow_dl.pop_front());
          void'(shadow_tag.pop_front());
          n++;
        end
        if (n > 0) cmd_answers[n-1].last = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string name, logic [DL_W-1:0] want, logic [DL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic issue_cmd(input in_item_t c, input bit fixed, input out_item_t ans);
    int unsigned gap;
    gap = (idle_on && $urandom_range(99) < 25) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      start   <= 1'b0;
      in_item <= random_cmd();
      @(negedge clk);
    end
    start         <= 1'b1;
    in_item       <= c;
    cmd_fixed     = fixed;
    cmd_fixed_ans = ans;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // result check, prediction on each command transfer, and stall watchdog
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (answers_due.size() == 0) begin
          $error("result with none expected: kind %0d deadline %0h tag %0h status %0d",
                 out_item.result_kind, out_item.deadline, out_item.tag, out_item.status);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          check_field("result_kind", DL_W'(want.result_kind), DL_W'(out_item.result_kind));
          check_field("deadline", want.deadline, out_item.deadline);
          check_field("tag", DL_W'(want.tag), DL_W'(out_item.tag));
          check_field("status", DL_W'(want.status), DL_W'(out_item.status));
          check_field("last", DL_W'(want.last), DL_W'(out_item.last));
        end
      end
      if (start && !busy) begin
        predict_timer_cmd(in_item);
        if (cmd_fixed) answers_due.push_back(cmd_fixed_ans);
        else foreach (cmd_answers[i]) answers_due.push_back(cmd_answers[i]);
      end
      if (out_strobe || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_item_t    c;
    logic [DL_W-1:0] clock_now;
    int unsigned n;
    int unsigned roll;
    int unsigned k;

    // directed table: empty queue, zero delay, wrap and step-over, cancel
    // misses and hits, unused kind, fill to full, then drain a full queue
    dir_table = '{
      '{1,  make_cmd(KIND_TICK, '1, '0, '0, 8'h00), 1'b0, '0},
      '{1,  make_cmd(KIND_CANCEL, '0, '0, 32'h0, 8'h5A), 1'b1,
            make_ans(RES_CANCEL, 32'h0, 8'h5A, STAT_NOT_FOUND, 1'b1)},
      '{1,  make_cmd(KIND_ADD, 32'd123, 32'h0, '0, 8'hFF), 1'b1,
            make_ans(RES_ADD, 32'h0, 8'hFF, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_ADD, 32'h0, 32'h0, '0, 8'h00), 1'b1,
            make_ans(RES_ADD, 32'h1, 8'h00, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_ADD, '1, '1, '0, 8'h80), 1'b1,
            make_ans(RES_ADD, 32'hFFFF_FFFE, 8'h80, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_ADD, '1, 32'h1, '0, 8'h01), 1'b1,
            make_ans(RES_ADD, 32'h2, 8'h01, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_ADD, 32'hFFFF_FFFE, 32'h1, '0, 8'h7F), 1'b1,
            make_ans(RES_ADD, 32'hFFFF_FFFF, 8'h7F, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_ADD, 32'hFFFF_FFFE, 32'h1, '0, 8'hAA), 1'b1,
            make_ans(RES_ADD, 32'h3, 8'hAA, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_CANCEL, '0, '0, 32'h0, 8'h11), 1'b1,
            make_ans(RES_CANCEL, 32'h0, 8'h11, STAT_NOT_FOUND, 1'b1)},
      '{1,  make_cmd(KIND_CANCEL, '0, '0, 32'h5, 8'h22), 1'b1,
            make_ans(RES_CANCEL, 32'h5, 8'h22, STAT_NOT_FOUND, 1'b1)},
      '{1,  make_cmd(KIND_CANCEL, '0, '0, 32'hFFFF_FFFE, 8'h33), 1'b1,
            make_ans(RES_CANCEL, 32'hFFFF_FFFE, 8'h33, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_UNUSED, '1, '1, '1, 8'hFF), 1'b0, '0},
      '{1,  make_cmd(KIND_TICK, 32'h1, '0, '0, 8'h00), 1'b0, '0},
      '{13, make_cmd(KIND_ADD, 32'd1000, 32'd7, '0, 8'hC3), 1'b0, '0},
      '{1,  make_cmd(KIND_ADD, 32'h0, 32'h0, '0, 8'h3C), 1'b1,
            make_ans(RES_ADD, 32'h0, 8'h3C, STAT_FULL, 1'b1)},
      '{1,  make_cmd(KIND_CANCEL, '0, '0, 32'd1010, 8'h44), 1'b1,
            make_ans(RES_CANCEL, 32'd1010, 8'h44, STAT_OK, 1'b1)},
      '{1,  make_cmd(KIND_ADD, 32'd1000, 32'd10, '0, 8'h55), 1'b0, '0},
      '{1,  make_cmd(KIND_TICK, '1, '0, '0, 8'h00), 1'b0, '0}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[r])
      for (k = 0; k < dir_table[r].reps; k++)
        issue_cmd(dir_table[r].cmd, dir_table[r].fixed, dir_table[r].ans);

    // random commands against a slowly moving clock
    clock_now = 32'd500;
    n = 0;
    while (n < RANDOM_CMDS) begin
      idle_on = !(n >= 100 && n < 180);
      clock_now = clock_now + $urandom_range(0, 4);
      roll = $urandom_range(99);
      if (roll < 3) clock_now = $urandom;
      else if (roll < 5) clock_now = 32'hFFFF_FFF0 + $urandom_range(0, 12);
      c = random_cmd();
      roll = $urandom_range(99);
      if (roll < 45) begin
        c.kind = KIND_ADD;
        c.now_seconds = clock_now;
        k = $urandom_range(99);
        if (k < 10) c.delay_seconds = '0;
        else if (k >= 20) c.delay_seconds = $urandom_range(1, 40);
      end else if (roll < 70) begin
        c.kind = KIND_CANCEL;
        k = $urandom_range(99);
        if (k < 15) c.cancel_deadline = '0;
        else if (k < 75 && shadow_dl.size() > 0)
          c.cancel_deadline = shadow_dl[$urandom_range(shadow_dl.size() - 1)];
        else if (k < 85 && shadow_dl.size() > 0)
          c.cancel_deadline = shadow_dl[$urandom_range(shadow_dl.size() - 1)] + 1'b1;
      end else if (roll < 95) begin
        c.kind = KIND_TICK;
        if ($urandom_range(99) >= 15) c.now_seconds = clock_now;
      end else begin
        c.kind = KIND_UNUSED;
      end
      issue_cmd(c, 1'b0, '0);
      if (c.kind != KIND_UNUSED) n++;
    end
    start <= 1'b0;

    // drain, then let any trailing work settle
    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/sdtq_pkg.sv
hw/rtl/sdtq_cell.sv
hw/rtl/sdtq_chain.sv
hw/rtl/sorted_deadline_timer_queue.sv
hw/rtl/sdtq_checker.sv
sim/tb_sorted_deadline_timer_queue.sv
